>>> rtl/pdfr_pkg.sv
// Shared widths, register indexes and reset values for the pulse-distance frame receiver.
package pdfr_pkg;

	localparam int TIME_W  = 32;
	localparam int REG_W   = 20;
	localparam int SHIFT_W = 32;
	localparam int BYTE_W  = 8;
	localparam int INDEX_W = 3;

	// Fixed byte positions within the 32-bit frame shift register.
	localparam int ADDR_LSB     = 24;
	localparam int ADDR_CPL_LSB = 16;
	localparam int DATA_LSB     = 8;
	localparam int DATA_CPL_LSB = 0;

	localparam logic [INDEX_W-1:0] REG_ZERO_LOW   = 3'd0;
	localparam logic [INDEX_W-1:0] REG_ZERO_HIGH  = 3'd1;
	localparam logic [INDEX_W-1:0] REG_ONE_LOW    = 3'd2;
	localparam logic [INDEX_W-1:0] REG_ONE_HIGH   = 3'd3;
	localparam logic [INDEX_W-1:0] REG_START_LOW  = 3'd4;
	localparam logic [INDEX_W-1:0] REG_START_HIGH = 3'd5;

	localparam logic [REG_W-1:0] ZERO_LOW_RST   = 20'd900;
	localparam logic [REG_W-1:0] ZERO_HIGH_RST  = 20'd1400;
	localparam logic [REG_W-1:0] ONE_LOW_RST    = 20'd1900;
	localparam logic [REG_W-1:0] ONE_HIGH_RST   = 20'd2600;
	localparam logic [REG_W-1:0] START_LOW_RST  = 20'd8000;
	localparam logic [REG_W-1:0] START_HIGH_RST = 20'd14000;

endpackage

>>> rtl/pulse_distance_frame_receiver.sv
// Pulse-distance frame receiver: edge-interval classifier, frame shifter and result register.

// Takes one rising-edge timestamp (microseconds, wrapping at 2^32) per transaction and
// accepts a new one every clock cycle unless stalled. A timestamp is captured in an input
// register; from there one 32-bit subtract, six window compares and the frame shift are
// done, and a completed frame lands in the output register, so out_valid rises once the
// frame-completing edge has passed the input register. The only stall comes from the
// output register: while it holds an untaken result, a second frame-completing edge waits
// in the input register and in_ready drops. The user must write window registers through
// cfg_we / cfg_index / cfg_wdata only while no transaction is in flight; the block itself
// does not enforce this. Bounds are exclusive and checked in the order zero bit, one bit,
// start mark. Intervals below zero_low_us are dropped as glitches.
module pulse_distance_frame_receiver #(
	parameter int FRAME_BITS = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [pdfr_pkg::INDEX_W-1:0]         cfg_index,
	input  logic [pdfr_pkg::REG_W-1:0]           cfg_wdata,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [pdfr_pkg::TIME_W-1:0]          edge_time_us,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [pdfr_pkg::BYTE_W-1:0]          frame_address,
	output logic [pdfr_pkg::BYTE_W-1:0]          frame_data,
	output logic                                 check_ok
);

	localparam int CNT_W = $clog2(FRAME_BITS + 1);
	localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(FRAME_BITS - 1);

	// window registers
	logic [pdfr_pkg::REG_W-1:0] zero_low_q, zero_high_q, one_low_q, one_high_q;
	logic [pdfr_pkg::REG_W-1:0] start_low_q, start_high_q;

	// input register
	logic                        valid_s1;
	logic [pdfr_pkg::TIME_W-1:0] edge_time_s1;

	// receiver state
	logic [pdfr_pkg::TIME_W-1:0]  last_edge_q;
	logic                         have_last_q;
	logic [pdfr_pkg::SHIFT_W-1:0] shift_q;
	logic [CNT_W-1:0]             bits_q;
	logic                         armed_q;

	// result register
	logic                        out_valid_q;
	logic [pdfr_pkg::BYTE_W-1:0] addr_q, data_q;
	logic                        ok_q;

	logic [pdfr_pkg::TIME_W-1:0]  delta;
	logic                         glitch, is_zero, is_one, is_start;
	logic                         take_bit, start_hit, full;
	logic [pdfr_pkg::SHIFT_W-1:0] shift_next;
	logic                         advance_s1, load_s1;
	logic [pdfr_pkg::BYTE_W-1:0]  addr_n, addr_cpl_n, data_n, data_cpl_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_low_q   <= pdfr_pkg::ZERO_LOW_RST;
			zero_high_q  <= pdfr_pkg::ZERO_HIGH_RST;
			one_low_q    <= pdfr_pkg::ONE_LOW_RST;
			one_high_q   <= pdfr_pkg::ONE_HIGH_RST;
			start_low_q  <= pdfr_pkg::START_LOW_RST;
			start_high_q <= pdfr_pkg::START_HIGH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pdfr_pkg::REG_ZERO_LOW:   zero_low_q   <= cfg_wdata;
				pdfr_pkg::REG_ZERO_HIGH:  zero_high_q  <= cfg_wdata;
				pdfr_pkg::REG_ONE_LOW:    one_low_q    <= cfg_wdata;
				pdfr_pkg::REG_ONE_HIGH:   one_high_q   <= cfg_wdata;
				pdfr_pkg::REG_START_LOW:  start_low_q  <= cfg_wdata;
				pdfr_pkg::REG_START_HIGH: start_high_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// classification of the interval held in the input register
	always_comb begin
		delta     = edge_time_s1 - last_edge_q;
		glitch    = delta < pdfr_pkg::TIME_W'(zero_low_q);
		is_zero   = (delta > pdfr_pkg::TIME_W'(zero_low_q)) &&
		            (delta < pdfr_pkg::TIME_W'(zero_high_q));
		is_one    = (delta > pdfr_pkg::TIME_W'(one_low_q)) &&
		            (delta < pdfr_pkg::TIME_W'(one_high_q));
		is_start  = (delta > pdfr_pkg::TIME_W'(start_low_q)) &&
		            (delta < pdfr_pkg::TIME_W'(start_high_q));
		take_bit  = have_last_q && !glitch && armed_q && (is_zero || is_one);
		start_hit = have_last_q && !glitch && !is_zero && !is_one && is_start;
		full      = take_bit && (bits_q == LAST_BIT);
		// zero window wins when both bit windows match
		shift_next = {shift_q[pdfr_pkg::SHIFT_W-2:0], !is_zero};
		addr_n     = shift_next[pdfr_pkg::ADDR_LSB     +: pdfr_pkg::BYTE_W];
		addr_cpl_n = shift_next[pdfr_pkg::ADDR_CPL_LSB +: pdfr_pkg::BYTE_W];
		data_n     = shift_next[pdfr_pkg::DATA_LSB     +: pdfr_pkg::BYTE_W];
		data_cpl_n = shift_next[pdfr_pkg::DATA_CPL_LSB +: pdfr_pkg::BYTE_W];
	end

	// only a frame-completing transaction has to wait for a free output register
	assign advance_s1 = valid_s1 && !(full && out_valid_q && !out_ready);
	assign in_ready   = !valid_s1 || advance_s1;
	assign load_s1    = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			edge_time_s1 <= edge_time_us;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_edge_q <= '0;
			have_last_q <= 1'b0;
			shift_q     <= '0;
			bits_q      <= '0;
			armed_q     <= 1'b0;
		end else if (advance_s1) begin
			priority if (!have_last_q) begin
				last_edge_q <= edge_time_s1;
				have_last_q <= 1'b1;
			end else if (!glitch) begin
				last_edge_q <= edge_time_s1;
				if (take_bit) begin
					shift_q <= shift_next;
					bits_q  <= bits_q + CNT_W'(1);
					if (full) begin
						armed_q <= 1'b0;
					end
				end else if (start_hit) begin
					shift_q <= '0;
					bits_q  <= '0;
					armed_q <= 1'b1;
				end
			end else begin
				// glitch: edge time and frame hold
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1 && full) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && full) begin
			addr_q <= addr_n;
			data_q <= data_n;
			ok_q   <= (addr_cpl_n == ~addr_n) && (data_cpl_n == ~data_n);
		end
	end

	assign out_valid     = out_valid_q;
	assign frame_address = addr_q;
	assign frame_data    = data_q;
	assign check_ok      = ok_q;

endmodule

>>> rtl/pdfr_checker.sv
// Port-level checks for the pulse-distance frame receiver, bound to the top level.
module pdfr_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [pdfr_pkg::BYTE_W-1:0] frame_address,
	input logic [pdfr_pkg::BYTE_W-1:0] frame_data,
	input logic                        check_ok
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(frame_address) &&
		$stable(frame_data) && $stable(check_ok))
	else $error("result changed while stalled");

	// input backpressure only comes from a blocked output register
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
	else $error("input stalled without output backpressure");

	// a fresh result is always caused by an accepted input transaction that has passed the input register
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
	else $error("result without a matching input transaction");

endmodule

bind pulse_distance_frame_receiver pdfr_checker u_pdfr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.frame_address(frame_address),
	.frame_data   (frame_data),
	.check_ok     (check_ok)
);
